/* rtl/core/ssmp_pkg.sv */
package ssmp_pkg;

  // field and state widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned MaskW     = 64;
  localparam int unsigned DayBits   = 7;
  localparam int unsigned DayShift  = 48;
  localparam int unsigned SlotBits  = 49;
  localparam int unsigned SlotLimit = 48;
  localparam int unsigned WinDepth  = 4;
  localparam int unsigned WinIdxW   = 2;
  localparam int unsigned FillW     = 3;
  localparam int unsigned SlotW     = 8;

  typedef logic [ByteW-1:0]    byte_t;
  typedef logic [DayBits-1:0]  days_t;
  typedef logic [SlotBits-1:0] slots_t;
  typedef logic [MaskW-1:0]    mask_t;
  typedef logic [FillW-1:0]    fill_t;
  typedef logic [SlotW-1:0]    slot_t;

  // character codes
  localparam byte_t CharNul   = 8'h00;
  localparam byte_t CharMon   = 8'h4D;  // M
  localparam byte_t CharTue   = 8'h54;  // T
  localparam byte_t CharWed   = 8'h57;  // W
  localparam byte_t CharFri   = 8'h46;  // F
  localparam byte_t CharSat   = 8'h53;  // S
  localparam byte_t CharLowH  = 8'h68;  // h
  localparam byte_t CharLowU  = 8'h75;  // u
  localparam byte_t CharColon = 8'h3A;
  localparam byte_t CharZero  = 8'h30;
  localparam byte_t CharNine  = 8'h39;
  localparam byte_t CharTwo   = 8'h32;
  localparam byte_t CharThree = 8'h33;
  localparam byte_t CharFive  = 8'h35;

  // weekday flags, monday first
  localparam days_t DayMon = 7'b0000001;
  localparam days_t DayTue = 7'b0000010;
  localparam days_t DayWed = 7'b0000100;
  localparam days_t DayThu = 7'b0001000;
  localparam days_t DayFri = 7'b0010000;
  localparam days_t DaySat = 7'b0100000;
  localparam days_t DaySun = 7'b1000000;

  function automatic days_t decode_day(byte_t cur, byte_t nxt);
    days_t res;
    case (cur)
      CharMon: res = DayMon;
      CharTue: res = (nxt == CharLowH) ? DayThu : DayTue;
      CharWed: res = DayWed;
      CharFri: res = DayFri;
      CharSat: res = (nxt == CharLowU) ? DaySun : DaySat;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic digit_ok(byte_t c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // one-hot half-hour slot for a token hh:mm, zero if no token or out of range
  function automatic slots_t decode_time(byte_t a, byte_t b, byte_t colon, byte_t d, byte_t e);
    logic   ok;
    slot_t  tens;
    slot_t  units;
    slot_t  slot;
    slots_t res;
    ok    = digit_ok(a) && digit_ok(b) && (colon == CharColon) && digit_ok(d) && digit_ok(e);
    tens  = slot_t'(a[3:0]);
    units = slot_t'(b[3:0]);
    slot  = (tens << 3) + (tens << 1) + units;
    slot  = slot << 1;
    if ((d == CharTwo) || (d == CharThree)) begin
      slot = slot + slot_t'(1);
    end else if (d == CharFive) begin
      slot = slot + slot_t'(2);
    end
    res = '0;
    if (ok && (slot <= slot_t'(SlotLimit))) begin
      res = slots_t'(1) << slot[5:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/ssmp_if.sv */
interface ssmp_text_if;
  logic                valid;
  logic                ready;
  ssmp_pkg::byte_t     text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ssmp_mask_if;
  logic                valid;
  logic                ready;
  ssmp_pkg::mask_t     result_mask;

  modport source (output valid, output result_mask, input ready);
  modport sink   (input valid, input result_mask, output ready);
endinterface

/* rtl/core/section_schedule_mask_parser_unit.sv */
// Schedule mask parser: takes one text byte per transfer and, on the
// terminating zero byte, returns one 64-bit mask (bits 0-47 the half-hour
// span between the first time token and the OR of all later ones, bits 48-54
// the weekday flags, Monday first), then starts afresh for the next string.
// A byte is taken into an input register and decoded in the following cycle
// against a four-byte window, so one byte is accepted every clock unless
// stalled; the terminator's mask is registered in an output register. Input
// stalls only while a terminator waits behind a mask that is not yet taken.
module section_schedule_mask_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssmp_text_if.sink   text_i,
  ssmp_mask_if.source mask_o
);

  logic                                   in_valid_q;
  ssmp_pkg::byte_t                        in_byte_q;
  ssmp_pkg::byte_t [ssmp_pkg::WinDepth-1:0] win_q;
  ssmp_pkg::fill_t                        fill_q;
  ssmp_pkg::days_t                        days_q;
  ssmp_pkg::slots_t                       start_q;
  ssmp_pkg::slots_t                       end_q;
  logic                                   out_valid_q;
  ssmp_pkg::mask_t                        out_mask_q;

  logic                                   is_term;
  logic                                   advance;
  logic [ssmp_pkg::WinIdxW-1:0]           newest_idx;
  ssmp_pkg::byte_t                        newest;
  ssmp_pkg::days_t                        days_d;
  ssmp_pkg::slots_t                       slot_hit;
  ssmp_pkg::mask_t                        span;
  ssmp_pkg::mask_t                        mask_d;

  // stage control
  assign is_term      = (in_byte_q == ssmp_pkg::CharNul);
  assign advance      = in_valid_q && (!is_term || !out_valid_q || mask_o.ready);
  assign text_i.ready = !in_valid_q || advance;

  // day decode of the newest window byte against the incoming one
  assign newest_idx = ssmp_pkg::WinIdxW'(fill_q - ssmp_pkg::fill_t'(1));
  assign newest     = win_q[newest_idx];
  always_comb begin
    days_d = days_q;
    if (fill_q != '0) begin
      days_d = days_q | ssmp_pkg::decode_day(newest, in_byte_q);
    end
  end

  // time token over the full window plus the incoming byte
  always_comb begin
    slot_hit = '0;
    if (fill_q == ssmp_pkg::fill_t'(ssmp_pkg::WinDepth)) begin
      slot_hit = ssmp_pkg::decode_time(win_q[0], win_q[1], win_q[2], win_q[3], in_byte_q);
    end
  end

  // result mask
  assign span   = (ssmp_pkg::mask_t'(start_q) - ssmp_pkg::mask_t'(1))
                ^ (ssmp_pkg::mask_t'(end_q) - ssmp_pkg::mask_t'(1));
  assign mask_d = span | (ssmp_pkg::mask_t'(days_d) << ssmp_pkg::DayShift);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      in_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.ready && text_i.valid) begin
      in_byte_q <= text_i.text_byte;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      days_q  <= '0;
      start_q <= '0;
      end_q   <= '0;
    end else if (advance) begin
      if (is_term) begin
        win_q   <= '0;
        fill_q  <= '0;
        days_q  <= '0;
        start_q <= '0;
        end_q   <= '0;
      end else begin
        days_q <= days_d;
        if (slot_hit != '0) begin
          if (start_q == '0) begin
            start_q <= slot_hit;
          end else begin
            end_q <= end_q | slot_hit;
          end
        end
        if (fill_q == ssmp_pkg::fill_t'(ssmp_pkg::WinDepth)) begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= win_q[3];
          win_q[3] <= in_byte_q;
        end else begin
          win_q[fill_q[ssmp_pkg::WinIdxW-1:0]] <= in_byte_q;
          fill_q <= fill_q + ssmp_pkg::fill_t'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_term) begin
      out_valid_q <= 1'b1;
    end else if (mask_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_term) begin
      out_mask_q <= mask_d;
    end
  end

  assign mask_o.valid       = out_valid_q;
  assign mask_o.result_mask = out_mask_q;

endmodule

/* rtl/core/ssmp_checker.sv */
module ssmp_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input ssmp_pkg::byte_t text_byte_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input ssmp_pkg::mask_t result_mask_i
);

  // a held mask stays put until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_mask_i))
    else $error("mask changed or dropped while stalled");

  // a fresh mask follows an earlier terminator transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |->
      $past(in_valid_i && in_ready_i && (text_byte_i == ssmp_pkg::CharNul), 2))
    else $error("mask without terminator");

  // input only backs up behind a stalled mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // no mask straight out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("mask valid after reset");

endmodule

bind section_schedule_mask_parser_unit ssmp_checker u_ssmp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (text_i.valid),
  .in_ready_i    (text_i.ready),
  .text_byte_i   (text_i.text_byte),
  .out_valid_i   (mask_o.valid),
  .out_ready_i   (mask_o.ready),
  .result_mask_i (mask_o.result_mask)
);
